/* rtl/core/pfr_pkg.sv */
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared command codes, register indices and byte type for the paged framebuffer rasterizer.
// ----------------------------------------------------------------------------
package pfr_pkg;
	localparam logic [2:0] CMD_PLOT   = 3'd0;
	localparam logic [2:0] CMD_LINE   = 3'd1;
	localparam logic [2:0] CMD_CIRCLE = 3'd2;
	localparam logic [2:0] CMD_CLEAR  = 3'd3;
	localparam logic [2:0] CMD_READ   = 3'd4;
	localparam int unsigned REG_ROTATION   = 0;
	localparam int unsigned REG_ROW_OFFSET = 1;
	typedef logic [7:0] byte_t;
endpackage

/* rtl/core/paged_framebuffer_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// paged_framebuffer_rasterizer_unit
// Monochrome paged framebuffer with point, line and circle drawing.
// ----------------------------------------------------------------------------
// channel | signals                                       | role
// in      | in_valid/in_ready, cmd..read_page             | one command per item
// out     | out_valid/out_ready, read_data                | one result per item
// cfg     | cfg_we, cfg_index, cfg_data                   | rotation, row offset
// Each pixel is a read-modify-write of the frame memory through ST_GEN,
// ST_RD and ST_WR, with ST_GEN_FIX added for a circle of nonzero radius.
// Clear and the clearing pass after reset write zero to every byte in turn.
// No item is accepted during the clearing pass; a waiting result blocks
// acceptance of the next item, and the block works on one at a time.
module paged_framebuffer_rasterizer_unit
	import pfr_pkg::*;
#(
	parameter int WIDTH = 88,
	parameter int PAGES = 6
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [2:0] cmd,
	input  logic [7:0] pos_x,
	input  logic [7:0] pos_y,
	input  logic [7:0] end_x,
	input  logic [7:0] end_y,
	input  logic [7:0] radius,
	input  logic       set_pixel,
	input  logic [6:0] read_column,
	input  logic [2:0] read_page,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] read_data,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data
);
	localparam int DEPTH  = WIDTH * PAGES;
	localparam int AW     = $clog2(DEPTH);
	localparam int HEIGHT = PAGES * 8;
	localparam logic [7:0] WM1 = 8'(WIDTH - 1);
	localparam logic [7:0] HM1 = 8'(HEIGHT - 1);

	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_CLEAR   = 4'd1;
	localparam logic [3:0] ST_GEN     = 4'd2;  // pick next pixel
	localparam logic [3:0] ST_RD      = 4'd3;  // memory read issued
	localparam logic [3:0] ST_WR      = 4'd4;  // modify and write
	localparam logic [3:0] ST_READ    = 4'd5;
	localparam logic [3:0] ST_DONE    = 4'd6;
	localparam logic [3:0] ST_CTEST   = 4'd7;  // circle loop and step tests
	localparam logic [3:0] ST_CSTEP   = 4'd8;  // line setup
	localparam logic [3:0] ST_CMUL    = 4'd9;  // circle products
	localparam logic [3:0] ST_GEN_FIX = 4'd10;

	logic [3:0]  state_q;
	logic [2:0]  cmd_q;
	logic [7:0]  x0_q, y0_q;
	logic [AW-1:0] clr_q;
	logic [7:0]  res_q;
	logic        ovalid_q;
	logic [1:0]  rot_q;
	logic [7:0]  roff_q;

	// line stepping
	logic [8:0]  ldx_q, ldy_q, dist_q, erx_q, ery_q, n_q;
	logic        sxn_q, syn_q;
	// circle
	logic [8:0]  ca_q, cb_q;
	logic [7:0]  r_q;
	logic [2:0]  oct_q;
	logic [17:0] a2_q, b2_q, r2_q;
	logic        cphase_q; // 0: loop test, 1: step test

	// current pixel
	logic [7:0]  px_q, py_q;
	logic        pon_q;
	logic        pok_s1;
	logic [AW-1:0] paddr_s1;
	logic [7:0]  pmask_s1;

	// frame memory
	byte_t       mem [DEPTH];
	byte_t       rdata_q;
	logic        we;
	logic [AW-1:0] waddr, raddr;
	byte_t       wdata;

	// read address range check captured with the request
	logic read_column_ok_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE)
			read_column_ok_q <= (32'(read_column) < WIDTH) && (32'(read_page) < PAGES);
	end

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_q <= mem[raddr];
	end

	assign in_ready  = (state_q == ST_IDLE) && !(ovalid_q && !out_ready);
	assign out_valid = ovalid_q;
	assign read_data = res_q;

	// result slot free for a finished item
	logic done_fire;
	assign done_fire = (state_q == ST_DONE) && (!ovalid_q || out_ready);

	// pixel mapping
	logic [7:0] col_c, row_c, rowo_c;
	always_comb begin
		case (rot_q)
			2'd1: begin col_c = py_q; row_c = WM1 - px_q; end
			2'd2: begin col_c = WM1 - px_q; row_c = HM1 - py_q; end
			2'd3: begin col_c = HM1 - py_q; row_c = px_q; end
			default: begin col_c = px_q; row_c = py_q; end
		endcase
		rowo_c = row_c + roff_q;
	end

	// circle octet point
	logic [7:0] ocx, ocy, a8, b8;
	always_comb begin
		a8 = ca_q[7:0];
		b8 = cb_q[7:0];
		case (oct_q)
			3'd0: begin ocx = x0_q + a8; ocy = y0_q - b8; end
			3'd1: begin ocx = x0_q - a8; ocy = y0_q - b8; end
			3'd2: begin ocx = x0_q - a8; ocy = y0_q + b8; end
			3'd3: begin ocx = x0_q + a8; ocy = y0_q + b8; end
			3'd4: begin ocx = x0_q + b8; ocy = y0_q + a8; end
			3'd5: begin ocx = x0_q + b8; ocy = y0_q - a8; end
			3'd6: begin ocx = x0_q - b8; ocy = y0_q - a8; end
			default: begin ocx = x0_q - b8; ocy = y0_q + a8; end
		endcase
	end

	// memory port control
	always_comb begin
		we    = 1'b0;
		waddr = paddr_s1;
		wdata = pon_q ? (rdata_q | pmask_s1) : (rdata_q & ~pmask_s1);
		raddr = paddr_s1;
		if (state_q == ST_CLEAR) begin
			we = 1'b1; waddr = clr_q; wdata = '0;
		end else if (state_q == ST_WR && pok_s1) begin
			we = 1'b1;
		end
		if (state_q == ST_IDLE)
			raddr = AW'(32'(read_column) * PAGES + 32'(read_page));
	end

	logic [9:0] lerx_c, lery_c;
	logic [18:0] cdiff_c;
	always_comb begin
		lerx_c = {1'b0, erx_q} + {1'b0, ldx_q};
		lery_c = {1'b0, ery_q} + {1'b0, ldy_q};
		cdiff_c = {1'b0, a2_q} + {1'b0, b2_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_CLEAR;
			cmd_q    <= CMD_PLOT;
			clr_q    <= '0;
			ovalid_q <= 1'b0;
			rot_q    <= 2'd0;
			roff_q   <= 8'd10;
		end else begin
			if (cfg_we) begin
				if (cfg_index == 1'(REG_ROTATION)) rot_q <= cfg_data[1:0];
				else roff_q <= cfg_data;
			end
			if (done_fire) ovalid_q <= 1'b1;
			else if (out_ready) ovalid_q <= 1'b0;
			case (state_q)
				ST_CLEAR: begin
					if (clr_q == AW'(DEPTH - 1)) begin
						clr_q <= '0;
						state_q <= (cmd_q == CMD_CLEAR) ? ST_DONE : ST_IDLE;
						cmd_q <= CMD_PLOT;
					end else clr_q <= clr_q + 1'b1;
				end
				ST_IDLE: begin
					if (in_valid && in_ready) begin
						cmd_q <= cmd; x0_q <= pos_x; y0_q <= pos_y;
						r_q <= radius;
						px_q <= pos_x; py_q <= pos_y; pon_q <= set_pixel;
						res_q <= '0;
						case (cmd)
							CMD_PLOT: state_q <= ST_GEN;
							CMD_LINE: begin
								sxn_q <= end_x < pos_x;
								syn_q <= end_y < pos_y;
								ldx_q <= (end_x < pos_x) ? 9'(pos_x - end_x)
									: 9'(end_x - pos_x);
								ldy_q <= (end_y < pos_y) ? 9'(pos_y - end_y)
									: 9'(end_y - pos_y);
								erx_q <= '0; ery_q <= '0; n_q <= '0;
								state_q <= ST_CSTEP;
							end
							CMD_CIRCLE: begin
								ca_q <= '0; cb_q <= {1'b0, radius};
								oct_q <= '0; pon_q <= 1'b1;
								cphase_q <= 1'b0;
								state_q <= (radius == 8'd0) ? ST_GEN : ST_CMUL;
							end
							CMD_CLEAR: state_q <= ST_CLEAR;
							CMD_READ: state_q <= ST_READ;
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_READ: begin
					if (read_column_ok_q) res_q <= rdata_q;
					state_q <= ST_DONE;
				end
				ST_CSTEP: begin
					// line setup: distance
					dist_q <= (ldx_q > ldy_q) ? ldx_q : ldy_q;
					state_q <= ST_GEN;
				end
				ST_GEN: begin
					if (cmd_q == CMD_CIRCLE && r_q != 8'd0) begin
						px_q <= ocx; py_q <= ocy;
					end
					pok_s1   <= (col_c < 8'(WIDTH)) && (rowo_c < 8'(HEIGHT));
					paddr_s1 <= AW'(32'(col_c) * PAGES + 32'(rowo_c[7:3]));
					pmask_s1 <= 8'd1 << rowo_c[2:0];
					if (cmd_q == CMD_CIRCLE && r_q != 8'd0) state_q <= ST_GEN_FIX;
					else state_q <= ST_RD;
				end
				ST_GEN_FIX: begin
					pok_s1   <= (col_c < 8'(WIDTH)) && (rowo_c < 8'(HEIGHT));
					paddr_s1 <= AW'(32'(col_c) * PAGES + 32'(rowo_c[7:3]));
					pmask_s1 <= 8'd1 << rowo_c[2:0];
					state_q <= ST_RD;
				end
				ST_RD: state_q <= ST_WR;
				ST_WR: begin
					case (cmd_q)
						CMD_LINE: begin
							if (n_q == dist_q) state_q <= ST_DONE;
							else begin
								n_q <= n_q + 1'b1;
								if (lerx_c > {1'b0, dist_q}) begin
									erx_q <= 9'(lerx_c - {1'b0, dist_q});
									px_q <= sxn_q ? px_q - 1'b1 : px_q + 1'b1;
								end else erx_q <= lerx_c[8:0];
								if (lery_c > {1'b0, dist_q}) begin
									ery_q <= 9'(lery_c - {1'b0, dist_q});
									py_q <= syn_q ? py_q - 1'b1 : py_q + 1'b1;
								end else ery_q <= lery_c[8:0];
								state_q <= ST_GEN;
							end
						end
						CMD_CIRCLE: begin
							if (r_q == 8'd0) state_q <= ST_DONE;
							else if (oct_q == 3'd7) begin
								oct_q <= '0;
								ca_q <= ca_q + 1'b1;
								cphase_q <= 1'b1;
								state_q <= ST_CMUL;
							end else begin
								oct_q <= oct_q + 1'b1;
								state_q <= ST_GEN;
							end
						end
						default: state_q <= ST_DONE;
					endcase
				end
				ST_CMUL: begin
					a2_q <= 18'(ca_q) * 18'(ca_q);
					b2_q <= 18'(cb_q) * 18'(cb_q);
					r2_q <= 18'(r_q) * 18'(r_q);
					state_q <= ST_CTEST;
				end
				ST_CTEST: begin
					if (cphase_q) begin
						// step test: a*a + b*b > r*r
						cphase_q <= 1'b0;
						if (cdiff_c > {1'b0, r2_q}) begin
							ca_q <= ca_q - 1'b1; cb_q <= cb_q - 1'b1;
						end
						state_q <= ST_CMUL;
					end else begin
						// loop test: 2*b*b >= r*r
						if ({b2_q, 1'b0} >= {1'b0, r2_q}) state_q <= ST_GEN;
						else state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_fire) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

/* sim/tb_paged_framebuffer_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// tb_paged_framebuffer_rasterizer_unit
// Drives plot, line, circle, clear and read commands through the rasterizer
// under several rotation and row offset settings and checks every read_data
// against a pixel-accurate shadow of the frame memory.
// ----------------------------------------------------------------------------
module tb_paged_framebuffer_rasterizer_unit;
	import pfr_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIDTH = 88;
	localparam int PAGES = 6;
	localparam int HEIGHT = PAGES * 8;
	localparam int CYCLE_LIMIT = 60000000;

	typedef struct packed {
		logic [2:0] cmd;
		logic [7:0] pos_x;
		logic [7:0] pos_y;
		logic [7:0] end_x;
		logic [7:0] end_y;
		logic [7:0] radius;
		logic       set_pixel;
		logic [6:0] read_column;
		logic [2:0] read_page;
	} draw_cmd_t;

	logic clk, arst_n;
	logic in_valid, in_ready, out_valid, out_ready;
	logic [2:0] cmd;
	logic [7:0] pos_x, pos_y, end_x, end_y, radius;
	logic set_pixel;
	logic [6:0] read_column;
	logic [2:0] read_page;
	logic [7:0] read_data;
	logic cfg_we, cfg_index;
	logic [7:0] cfg_data;

	paged_framebuffer_rasterizer_unit #(.WIDTH(WIDTH), .PAGES(PAGES)) DUT (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.cmd(cmd), .pos_x(pos_x), .pos_y(pos_y), .end_x(end_x), .end_y(end_y),
		.radius(radius), .set_pixel(set_pixel),
		.read_column(read_column), .read_page(read_page),
		.out_valid(out_valid), .out_ready(out_ready), .read_data(read_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	// shadow of the frame memory and configuration
	byte_t      shadow_fb [WIDTH*PAGES];
	logic [1:0] shadow_rot;
	logic [7:0] shadow_offset;

	draw_cmd_t  pending_cmds[$];
	byte_t      expected_bytes[$];
	int         mismatches;
	int         cycles;
	int         send_idle_pct, recv_stall_pct;
	bit         hold_receiver;
	int         hold_cycles;
	logic       in_ready_seen;

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// length of the receiver hold-off
	always @(posedge clk) begin
		if (hold_receiver)
			hold_cycles <= hold_cycles + 1;
		else
			hold_cycles <= 0;
	end

	// one rotated pixel write into the shadow
	function automatic void put_px(logic [7:0] x, logic [7:0] y, bit on);
		logic [7:0] col, row;
		int idx;
		case (shadow_rot)
			2'd1: begin col = y; row = 8'(WIDTH - 1 - x); end
			2'd2: begin col = 8'(WIDTH - 1 - x); row = 8'(HEIGHT - 1 - y); end
			2'd3: begin col = 8'(HEIGHT - 1 - y); row = x; end
			default: begin col = x; row = y; end
		endcase
		row = row + shadow_offset;
		if (col >= WIDTH || row >= HEIGHT)
			return;
		idx = col * PAGES + (row >> 3);
		if (on)
			shadow_fb[idx] = shadow_fb[idx] | (8'd1 << row[2:0]);
		else
			shadow_fb[idx] = shadow_fb[idx] & ~(8'd1 << row[2:0]);
	endfunction

	// error-accumulate line, strict greater-than stepping
	function automatic void rasterize_line(int x1, int y1, int x2, int y2, bit on);
		int dx, dy, sx, sy, span, ax, ay, cx, cy;
		dx = x2 - x1; dy = y2 - y1; sx = 0; sy = 0; ax = 0; ay = 0;
		cx = x1; cy = y1;
		if (dx > 0) sx = 1;
		else if (dx < 0) begin sx = -1; dx = -dx; end
		if (dy > 0) sy = 1;
		else if (dy < 0) begin sy = -1; dy = -dy; end
		span = dx > dy ? dx : dy;
		for (int n = 0; n <= span; n++) begin
			put_px(8'(cx), 8'(cy), on);
			ax += dx; ay += dy;
			if (ax > span) begin ax -= span; cx += sx; end
			if (ay > span) begin ay -= span; cy += sy; end
		end
	endfunction

	// circle by squared-distance test, eight symmetric points per step
	function automatic void rasterize_circle(int cx, int cy, int r);
		int a, b;
		a = 0; b = r;
		if (r == 0) begin
			put_px(8'(cx), 8'(cy), 1'b1);
			return;
		end
		while (2 * b * b >= r * r) begin
			put_px(8'(cx + a), 8'(cy - b), 1'b1);
			put_px(8'(cx - a), 8'(cy - b), 1'b1);
			put_px(8'(cx - a), 8'(cy + b), 1'b1);
			put_px(8'(cx + a), 8'(cy + b), 1'b1);
			put_px(8'(cx + b), 8'(cy + a), 1'b1);
			put_px(8'(cx + b), 8'(cy - a), 1'b1);
			put_px(8'(cx - b), 8'(cy - a), 1'b1);
			put_px(8'(cx - b), 8'(cy + a), 1'b1);
			a++;
			if (a * a + b * b - r * r > 0) begin
				b--;
				a--;
			end
		end
	endfunction

	// apply one command to the shadow and return its read byte
	function automatic byte_t apply_command(draw_cmd_t c);
		byte_t data;
		data = '0;
		case (c.cmd)
			CMD_PLOT: put_px(c.pos_x, c.pos_y, c.set_pixel);
			CMD_LINE: rasterize_line(c.pos_x, c.pos_y, c.end_x, c.end_y, c.set_pixel);
			CMD_CIRCLE: rasterize_circle(c.pos_x, c.pos_y, c.radius);
			CMD_CLEAR: foreach (shadow_fb[i]) shadow_fb[i] = '0;
			CMD_READ:
				if (c.read_column < WIDTH && c.read_page < PAGES)
					data = shadow_fb[c.read_column * PAGES + c.read_page];
			default: ;
		endcase
		return data;
	endfunction

	// driver: offer queued items, predict on acceptance
	always @(negedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready_seen) begin
				expected_bytes.push_back(apply_command(pending_cmds.pop_front()));
			end
			if (!(in_valid && !in_ready_seen)) begin
				if (pending_cmds.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					{cmd, pos_x, pos_y, end_x, end_y, radius, set_pixel, read_column,
						read_page} <= pending_cmds[0];
				end else begin
					in_valid <= 1'b0;
				end
			end
			// receiver stall, with a long hold-off on request
			if (hold_receiver) begin
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= recv_stall_pct);
			end
		end
	end

	// acceptance seen at the rising edge, consumed by the driver at the falling edge
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			in_ready_seen <= 1'b0;
		else
			in_ready_seen <= in_valid && in_ready;
	end

	// monitor: compare each result with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_bytes.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected item: read_data %h", read_data);
			end else begin
				byte_t want;
				want = expected_bytes.pop_front();
				if (read_data !== want) begin
					mismatches++;
					if (mismatches <= 10)
						$display("read_data mismatch: expected %h actual %h", want, read_data);
				end
			end
		end
	end

	function automatic draw_cmd_t rand_cmd();
		draw_cmd_t c;
		int pick;
		c = draw_cmd_t'({$urandom, $urandom});
		pick = $urandom_range(99);
		if (pick < 30) c.cmd = CMD_PLOT;
		else if (pick < 45) c.cmd = CMD_LINE;
		else if (pick < 55) c.cmd = CMD_CIRCLE;
		else if (pick < 57) c.cmd = CMD_CLEAR;
		else if (pick < 95) c.cmd = CMD_READ;
		else c.cmd = 3'($urandom_range(5, 7));
		// keep most coordinates near the visible area
		if ($urandom_range(3) != 0) begin
			c.pos_x = 8'($urandom_range(0, 95)); c.pos_y = 8'($urandom_range(0, 95));
			c.end_x = 8'($urandom_range(0, 95)); c.end_y = 8'($urandom_range(0, 95));
			c.radius = 8'($urandom_range(0, 40));
		end
		if ($urandom_range(9) != 0) begin
			c.read_column = 7'($urandom_range(0, WIDTH - 1));
			c.read_page = 3'($urandom_range(0, PAGES - 1));
		end
		return c;
	endfunction

	function automatic draw_cmd_t make_cmd(logic [2:0] op, int x, int y, int x2, int y2,
			int r, bit on, int col, int pg);
		draw_cmd_t c;
		c.cmd = op; c.pos_x = 8'(x); c.pos_y = 8'(y); c.end_x = 8'(x2); c.end_y = 8'(y2);
		c.radius = 8'(r); c.set_pixel = on; c.read_column = 7'(col);
		c.read_page = 3'(pg);
		return c;
	endfunction

	task automatic wait_drained();
		while (pending_cmds.size() > 0 || expected_bytes.size() > 0 || in_valid)
			@(posedge clk);
		repeat (WIDTH * PAGES + 50) @(posedge clk);
	endtask

	task automatic write_reg(logic idx, logic [7:0] val);
		@(negedge clk);
		cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == 1'(REG_ROTATION)) shadow_rot = val[1:0];
		else shadow_offset = val;
	endtask

	task automatic queue_random(int n);
		repeat (n) pending_cmds.push_back(rand_cmd());
	endtask

	initial begin
		logic [1:0] rots [4];
		logic [7:0] offs [4];
		rots = '{2'd0, 2'd1, 2'd2, 2'd3};
		offs = '{8'd0, 8'd255, 8'd10, 8'd200};
		mismatches = 0;
		in_valid = 1'b0; out_ready = 1'b0; cfg_we = 1'b0; cfg_index = 1'b0;
		cfg_data = '0; cmd = '0; pos_x = '0; pos_y = '0; end_x = '0; end_y = '0;
		radius = '0; set_pixel = 1'b0; read_column = '0; read_page = '0;
		hold_receiver = 1'b0;
		send_idle_pct = 0; recv_stall_pct = 0;
		foreach (shadow_fb[i]) shadow_fb[i] = '0;
		shadow_rot = 2'd0; shadow_offset = 8'd10;
		arst_n = 1'b0;
		repeat (7) @(posedge clk);
		arst_n = 1'b1;

		// directed: extremes, every command, zero radius, bad read, unused codes
		pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_PLOT, 0, 0, 0, 0, 0, 1, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_PLOT, 255, 255, 0, 0, 0, 1, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_PLOT, 87, 37, 0, 0, 0, 1, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 1));
		pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 87, 5));
		pending_cmds.push_back(make_cmd(CMD_LINE, 0, 0, 87, 37, 0, 1, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_LINE, 80, 30, 3, 2, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_LINE, 5, 5, 5, 5, 0, 1, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_CIRCLE, 40, 20, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_CIRCLE, 40, 20, 0, 0, 15, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_CIRCLE, 2, 2, 0, 0, 255, 1, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 40, 1));
		pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 127, 7));
		pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 88, 0));
		pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 0, 6));
		pending_cmds.push_back(make_cmd(3'd5, 1, 1, 0, 0, 0, 1, 0, 0));
		pending_cmds.push_back(make_cmd(3'd7, 255, 255, 255, 255, 255, 1, 127, 7));
		pending_cmds.push_back(make_cmd(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0, 0));
		pending_cmds.push_back(make_cmd(CMD_READ, 0, 0, 0, 0, 0, 0, 40, 1));
		wait_drained();

		// random phases across settings and idling modes
		for (int p = 0; p < 8; p++) begin
			write_reg(1'(REG_ROTATION), 8'(p < 4 ? rots[p] : 2'($urandom)));
			write_reg(1'(REG_ROW_OFFSET), p < 4 ? offs[p] : 8'($urandom));
			case (p % 4)
				0: begin send_idle_pct = 0; recv_stall_pct = 0; end
				1: begin send_idle_pct = 56; recv_stall_pct = 0; end
				2: begin send_idle_pct = 0; recv_stall_pct = 56; end
				default: begin send_idle_pct = 8; recv_stall_pct = 8; end
			endcase
			queue_random(180);
			if (p == 2) begin
				// long receiver hold-off while items keep coming
				hold_receiver = 1'b1;
				while (hold_cycles < 3000) @(posedge clk);
				hold_receiver = 1'b0;
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_bytes.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end
endmodule

/* filelist.f */
rtl/core/pfr_pkg.sv
rtl/core/paged_framebuffer_rasterizer_unit.sv
sim/tb_paged_framebuffer_rasterizer_unit.sv
